// File: src/fragment_reassembler_macros.svh
// Assertion helpers for the fragment reassembler.
`ifndef FRAGMENT_REASSEMBLER_MACROS_SVH
`define FRAGMENT_REASSEMBLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fragment_reassembler: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fragment_reassembler: assertion failed");

`endif

// File: src/fr_pkg.sv
`timescale 1ns / 1ps
package fr_pkg;

    localparam int PAYLOAD_DEPTH = 8192;
    localparam int TOPIC_DEPTH   = 128;
    localparam int PAY_AW        = $clog2(PAYLOAD_DEPTH);
    localparam int TOP_AW        = $clog2(TOPIC_DEPTH);
    localparam int PAY_CW        = PAY_AW + 1;
    localparam int TOP_CW        = TOP_AW + 1;

    localparam logic [2:0] FUNC_HEADER  = 3'd0;
    localparam logic [2:0] FUNC_TOPIC   = 3'd1;
    localparam logic [2:0] FUNC_PAYLOAD = 3'd2;
    localparam logic [2:0] FUNC_RESTART = 3'd3;
    localparam logic [2:0] FUNC_RD_PAY  = 3'd4;
    localparam logic [2:0] FUNC_RD_TOP  = 3'd5;

    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
    localparam logic [2:0] KIND_COMPLETE = 3'd2;
    localparam logic [2:0] KIND_READ     = 3'd3;
    localparam logic [2:0] KIND_TOPIC    = 3'd4;

    localparam logic [2:0] VERD_FAST        = 3'd0;
    localparam logic [2:0] VERD_START       = 3'd1;
    localparam logic [2:0] VERD_CONT        = 3'd2;
    localparam logic [2:0] VERD_TOO_LARGE   = 3'd3;
    localparam logic [2:0] VERD_TOPIC_LONG  = 3'd4;
    localparam logic [2:0] VERD_NO_START    = 3'd5;
    localparam logic [2:0] VERD_MISORDER    = 3'd6;

    localparam logic [1:0] MODE_DISCARD = 2'd0;
    localparam logic [1:0] MODE_PASS    = 2'd1;
    localparam logic [1:0] MODE_STORE   = 2'd2;

    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_PAY  = 2'd1;
    localparam logic [1:0] RD_TOP  = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [19:0] frag_offset;
        logic [15:0] frag_len;
        logic [19:0] total_len;
        logic [15:0] topic_length;
        logic [7:0]  byte_in;
        logic [12:0] read_index;
    } frag_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  verdict;
        logic [7:0]  byte_out;
        logic        last;
        logic [13:0] message_length;
        logic [6:0]  message_topic_length;
        logic [31:0] message_count;
        logic [31:0] drop_count;
    } result_t;

endpackage

// File: src/fr_frag_if.sv
`timescale 1ns / 1ps
interface fr_frag_if;
    logic               valid;
    logic               ready;
    fr_pkg::frag_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/fr_result_if.sv
`timescale 1ns / 1ps
interface fr_result_if;
    logic            valid;
    logic            ready;
    fr_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/fragment_reassembler.sv
`timescale 1ns / 1ps
// Results are registered: one shows on rsp in the cycle after req accepts it.
// Throughput: one transaction per cycle; req stalls only while the output
// register holds a result that rsp has not taken.
// Reset (rst_n, async, active low) clears assembly state and counters;
// payload and topic stores are not cleared and hold garbage until written.
module fragment_reassembler (
    input logic         clk,
    input logic         rst_n,
    fr_frag_if.sink     req,
    fr_result_if.source rsp
);
    import fr_pkg::*;

    logic              act_reg, act_next;
    logic [PAY_CW-1:0] asm_reg, asm_next;
    logic [PAY_CW-1:0] exp_reg, exp_next;
    logic [TOP_AW-1:0] stl_reg, stl_next;
    logic [PAY_CW-1:0] pwp_reg, pwp_next;
    logic [TOP_CW-1:0] twp_reg, twp_next;
    logic [15:0]       bleft_reg, bleft_next;
    logic [15:0]       tleft_reg, tleft_next;
    logic [1:0]        mode_reg, mode_next;
    logic [31:0]       msg_cnt_reg, msg_cnt_next;
    logic [31:0]       drop_cnt_reg, drop_cnt_next;

    logic              out_valid_reg;
    result_t           res_reg, res_next;
    logic [1:0]        rd_src_reg, rd_src_next;
    logic              rd_zero_reg, rd_zero_next;
    logic [7:0]        pay_rd_reg;
    logic [7:0]        top_rd_reg;

    logic [7:0]        pay_mem [PAYLOAD_DEPTH];
    logic [7:0]        top_mem [TOPIC_DEPTH];

    frag_item_t        item;
    logic              accept;
    logic              emit;
    logic              pay_we;
    logic              top_we;

    assign item    = req.data;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept  = req.valid && req.ready;

    always_comb
    begin
        logic [16:0]       cont_end;
        logic [PAY_CW-1:0] asm_after;
        logic [15:0]       bleft_dec;

        cont_end  = 17'(asm_reg) + 17'(item.frag_len);
        bleft_dec = bleft_reg - 16'd1;
        asm_after = asm_reg;

        act_next      = act_reg;
        asm_next      = asm_reg;
        exp_next      = exp_reg;
        stl_next      = stl_reg;
        pwp_next      = pwp_reg;
        twp_next      = twp_reg;
        bleft_next    = bleft_reg;
        tleft_next    = tleft_reg;
        mode_next     = mode_reg;
        msg_cnt_next  = msg_cnt_reg;
        drop_cnt_next = drop_cnt_reg;

        emit         = 1'b0;
        pay_we       = 1'b0;
        top_we       = 1'b0;
        res_next     = '0;
        rd_src_next  = RD_NONE;
        rd_zero_next = 1'b0;

        case (item.func)
            FUNC_HEADER:
            begin
                emit = 1'b1;
                res_next.kind = KIND_HEADER;
                if (item.frag_offset == 20'd0 && 20'(item.frag_len) == item.total_len)
                begin
                    msg_cnt_next = msg_cnt_reg + 32'd1;
                    if (item.frag_len == 16'd0)
                    begin
                        // zero-length message completes at the header
                        mode_next  = MODE_DISCARD;
                        bleft_next = '0;
                        tleft_next = '0;
                        res_next.kind = KIND_COMPLETE;
                    end
                    else
                    begin
                        mode_next  = MODE_PASS;
                        bleft_next = item.frag_len;
                        tleft_next = item.topic_length;
                        res_next.verdict = VERD_FAST;
                    end
                end
                else if (item.frag_offset == 20'd0)
                begin
                    if (item.total_len > 20'(PAYLOAD_DEPTH))
                        res_next.verdict = VERD_TOO_LARGE;
                    else if (item.topic_length >= 16'(TOPIC_DEPTH))
                        res_next.verdict = VERD_TOPIC_LONG;
                    else if (20'(item.frag_len) > item.total_len)
                        res_next.verdict = VERD_MISORDER;
                    else
                        res_next.verdict = VERD_START;

                    act_next = 1'b0;
                    asm_next = '0;
                    exp_next = '0;
                    stl_next = '0;
                    pwp_next = '0;
                    twp_next = '0;
                    mode_next  = MODE_DISCARD;
                    bleft_next = '0;
                    tleft_next = '0;
                    if (res_next.verdict == VERD_START)
                    begin
                        act_next   = 1'b1;
                        exp_next   = PAY_CW'(item.total_len);
                        stl_next   = TOP_AW'(item.topic_length);
                        mode_next  = MODE_STORE;
                        bleft_next = item.frag_len;
                        tleft_next = item.topic_length;
                    end
                    else
                        drop_cnt_next = drop_cnt_reg + 32'd1;
                end
                else if (!act_reg)
                begin
                    res_next.verdict = VERD_NO_START;
                    drop_cnt_next = drop_cnt_reg + 32'd1;
                    mode_next  = MODE_DISCARD;
                    bleft_next = '0;
                    tleft_next = '0;
                end
                else if (item.frag_offset != 20'(asm_reg) ||
                         cont_end > 17'(PAYLOAD_DEPTH) || cont_end > 17'(exp_reg))
                begin
                    res_next.verdict = VERD_MISORDER;
                    drop_cnt_next = drop_cnt_reg + 32'd1;
                    act_next   = 1'b0;
                    asm_next   = '0;
                    exp_next   = '0;
                    stl_next   = '0;
                    pwp_next   = '0;
                    twp_next   = '0;
                    mode_next  = MODE_DISCARD;
                    bleft_next = '0;
                    tleft_next = '0;
                end
                else
                begin
                    res_next.verdict = VERD_CONT;
                    mode_next  = MODE_STORE;
                    bleft_next = item.frag_len;
                    tleft_next = '0;
                end
            end
            FUNC_TOPIC:
            begin
                if (tleft_reg != 16'd0 && mode_reg != MODE_DISCARD)
                begin
                    tleft_next = tleft_reg - 16'd1;
                    if (mode_reg == MODE_PASS)
                    begin
                        emit = 1'b1;
                        res_next.kind     = KIND_TOPIC;
                        res_next.byte_out = item.byte_in;
                    end
                    else if (twp_reg < TOP_CW'(TOPIC_DEPTH))
                    begin
                        top_we   = 1'b1;
                        twp_next = twp_reg + 1'b1;
                    end
                end
            end
            FUNC_PAYLOAD:
            begin
                if (bleft_reg != 16'd0 && mode_reg != MODE_DISCARD)
                begin
                    bleft_next = bleft_dec;
                    if (mode_reg == MODE_PASS)
                    begin
                        emit = 1'b1;
                        res_next.kind     = KIND_PAYLOAD;
                        res_next.byte_out = item.byte_in;
                        res_next.last     = (bleft_dec == 16'd0);
                    end
                    else
                    begin
                        if (pwp_reg < PAY_CW'(PAYLOAD_DEPTH))
                        begin
                            pay_we    = 1'b1;
                            pwp_next  = pwp_reg + 1'b1;
                            asm_after = asm_reg + 1'b1;
                            asm_next  = asm_after;
                        end
                        if (act_reg && asm_after == exp_reg)
                        begin
                            emit = 1'b1;
                            res_next.kind                 = KIND_COMPLETE;
                            res_next.message_length       = 14'(asm_after);
                            res_next.message_topic_length = 7'(stl_reg);
                            msg_cnt_next = msg_cnt_reg + 32'd1;
                            act_next   = 1'b0;
                            asm_next   = '0;
                            exp_next   = '0;
                            stl_next   = '0;
                            pwp_next   = '0;
                            twp_next   = '0;
                            mode_next  = MODE_DISCARD;
                            bleft_next = '0;
                            tleft_next = '0;
                        end
                    end
                end
            end
            FUNC_RESTART:
            begin
                act_next   = 1'b0;
                asm_next   = '0;
                exp_next   = '0;
                stl_next   = '0;
                pwp_next   = '0;
                twp_next   = '0;
                mode_next  = MODE_DISCARD;
                bleft_next = '0;
                tleft_next = '0;
            end
            FUNC_RD_PAY:
            begin
                emit = 1'b1;
                res_next.kind = KIND_READ;
                rd_src_next   = RD_PAY;
                rd_zero_next  = (32'(item.read_index) >= 32'(PAYLOAD_DEPTH));
            end
            FUNC_RD_TOP:
            begin
                emit = 1'b1;
                res_next.kind = KIND_READ;
                rd_src_next   = RD_TOP;
                rd_zero_next  = (32'(item.read_index) >= 32'(TOPIC_DEPTH));
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        res_next.message_count = msg_cnt_next;
        res_next.drop_count    = drop_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            asm_reg       <= '0;
            exp_reg       <= '0;
            stl_reg       <= '0;
            pwp_reg       <= '0;
            twp_reg       <= '0;
            bleft_reg     <= '0;
            tleft_reg     <= '0;
            mode_reg      <= MODE_DISCARD;
            msg_cnt_reg   <= '0;
            drop_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                act_reg      <= act_next;
                asm_reg      <= asm_next;
                exp_reg      <= exp_next;
                stl_reg      <= stl_next;
                pwp_reg      <= pwp_next;
                twp_reg      <= twp_next;
                bleft_reg    <= bleft_next;
                tleft_reg    <= tleft_next;
                mode_reg     <= mode_next;
                msg_cnt_reg  <= msg_cnt_next;
                drop_cnt_reg <= drop_cnt_next;
            end
            if (req.ready)
                out_valid_reg <= accept && emit;
        end
    end

    // result payload and store ports
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg     <= res_next;
            rd_src_reg  <= rd_src_next;
            rd_zero_reg <= rd_zero_next;
            if (pay_we)
                pay_mem[pwp_reg[PAY_AW-1:0]] <= item.byte_in;
            if (top_we)
                top_mem[twp_reg[TOP_AW-1:0]] <= item.byte_in;
            pay_rd_reg <= pay_mem[item.read_index[PAY_AW-1:0]];
            top_rd_reg <= top_mem[item.read_index[TOP_AW-1:0]];
        end
    end

    always_comb
    begin
        rsp.data = res_reg;
        if (rd_zero_reg && rd_src_reg != RD_NONE)
            rsp.data.byte_out = 8'd0;
        else if (rd_src_reg == RD_PAY)
            rsp.data.byte_out = pay_rd_reg;
        else if (rd_src_reg == RD_TOP)
            rsp.data.byte_out = top_rd_reg;
    end

    assign rsp.valid = out_valid_reg;

endmodule

// File: src/fr_checker.sv
`timescale 1ns / 1ps
`include "fragment_reassembler_macros.svh"
module fr_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input fr_pkg::result_t rsp_data
);
    import fr_pkg::*;

    `FR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `FR_ASSERT_IMPL(a_last_on_payload, rsp_valid && rsp_data.last, rsp_data.kind == KIND_PAYLOAD)
    `FR_ASSERT_IMPL(a_verdict_on_header, rsp_valid && rsp_data.verdict != VERD_FAST, rsp_data.kind == KIND_HEADER && rsp_data.byte_out == 8'd0)
    `FR_ASSERT_IMPL(a_len_in_range, rsp_valid && rsp_data.kind == KIND_COMPLETE, 32'(rsp_data.message_length) <= 32'(PAYLOAD_DEPTH))

endmodule

bind fragment_reassembler fr_checker u_fr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// File: tb/fragment_reassembler_test.sv
`timescale 1ns / 1ps
module fragment_reassembler_test;
    import fr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 250;
    localparam int unsigned ITEM_TARGET = 1150;
    localparam int BACKLOG_MAX = 8;

    logic clk = 1'b0;
    logic rst_n;

    fr_frag_if   req ();
    fr_result_if rsp ();

    fragment_reassembler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    frag_item_t frag_backlog[$];
    result_t    due_results[$];

    int          send_idle_pct = 0;
    int          rsp_stall_pct = 0;
    int unsigned offered = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    logic        hold_request;
    int unsigned hold_left;

    // Predictor state
    logic [7:0]        pay_mem [PAYLOAD_DEPTH];
    logic [7:0]        top_mem [TOPIC_DEPTH];
    bit                asm_active = 1'b0;
    logic [PAY_CW-1:0] asm_bytes = '0;
    logic [PAY_CW-1:0] asm_total = '0;
    logic [TOP_AW-1:0] asm_topic_len = '0;
    logic [PAY_CW-1:0] pay_wp = '0;
    logic [TOP_CW-1:0] top_wp = '0;
    logic [15:0]       pay_left = '0;
    logic [15:0]       top_left = '0;
    logic [1:0]        byte_mode_q = MODE_DISCARD;
    logic [31:0]       msgs_seen = '0;
    logic [31:0]       drops_seen = '0;
    int unsigned       pay_filled = 0;
    int unsigned       top_filled = 0;

    function automatic void clear_asm();
        asm_active    = 1'b0;
        asm_bytes     = '0;
        asm_total     = '0;
        asm_topic_len = '0;
        pay_wp        = '0;
        top_wp        = '0;
    endfunction

    function automatic void stop_bytes();
        byte_mode_q = MODE_DISCARD;
        pay_left    = '0;
        top_left    = '0;
    endfunction

    function automatic void reassemble(input frag_item_t it);
        result_t     r;
        bit          emitted;
        bit          reject;
        bit          wipe;
        logic [2:0]  code;
        int unsigned off;
        int unsigned flen;
        int unsigned tot;
        int unsigned tl;
        r = '0;
        emitted = 1'b0;
        reject = 1'b0;
        wipe = 1'b1;
        code = VERD_FAST;
        off = 32'(it.frag_offset);
        flen = 32'(it.frag_len);
        tot = 32'(it.total_len);
        tl = 32'(it.topic_length);
        case (it.func)
            FUNC_HEADER:
            begin
                emitted = 1'b1;
                r.kind = KIND_HEADER;
                if (off == 0 && flen == tot)
                begin
                    msgs_seen++;
                    if (flen == 0)
                    begin
                        stop_bytes();
                        r.kind = KIND_COMPLETE;
                    end
                    else
                    begin
                        byte_mode_q = MODE_PASS;
                        pay_left = 16'(flen);
                        top_left = 16'(tl);
                        r.verdict = VERD_FAST;
                    end
                end
                else if (off == 0)
                begin
                    if (tot > PAYLOAD_DEPTH)
                    begin
                        reject = 1'b1;
                        code = VERD_TOO_LARGE;
                    end
                    else if (tl + 1 > TOPIC_DEPTH)
                    begin
                        reject = 1'b1;
                        code = VERD_TOPIC_LONG;
                    end
                    else if (flen > tot)
                    begin
                        reject = 1'b1;
                        code = VERD_MISORDER;
                    end
                    else
                    begin
                        clear_asm();
                        asm_active = 1'b1;
                        asm_total = PAY_CW'(tot);
                        asm_topic_len = TOP_AW'(tl);
                        byte_mode_q = MODE_STORE;
                        pay_left = 16'(flen);
                        top_left = 16'(tl);
                        r.verdict = VERD_START;
                    end
                end
                else if (!asm_active)
                begin
                    reject = 1'b1;
                    wipe = 1'b0;
                    code = VERD_NO_START;
                end
                else if (off != 32'(asm_bytes) || 32'(asm_bytes) + flen > PAYLOAD_DEPTH ||
                         32'(asm_bytes) + flen > 32'(asm_total))
                begin
                    reject = 1'b1;
                    code = VERD_MISORDER;
                end
                else
                begin
                    byte_mode_q = MODE_STORE;
                    pay_left = 16'(flen);
                    top_left = '0;
                    r.verdict = VERD_CONT;
                end
                if (reject)
                begin
                    drops_seen++;
                    if (wipe)
                        clear_asm();
                    stop_bytes();
                    r.verdict = code;
                end
            end
            FUNC_TOPIC:
            begin
                if (top_left != 0 && byte_mode_q != MODE_DISCARD)
                begin
                    top_left--;
                    if (byte_mode_q == MODE_PASS)
                    begin
                        emitted = 1'b1;
                        r.kind = KIND_TOPIC;
                        r.byte_out = it.byte_in;
                    end
                    else if (32'(top_wp) < TOPIC_DEPTH)
                    begin
                        top_mem[top_wp[TOP_AW-1:0]] = it.byte_in;
                        top_wp++;
                        if (32'(top_wp) > top_filled)
                            top_filled = 32'(top_wp);
                    end
                end
            end
            FUNC_PAYLOAD:
            begin
                if (pay_left != 0 && byte_mode_q != MODE_DISCARD)
                begin
                    pay_left--;
                    if (byte_mode_q == MODE_PASS)
                    begin
                        emitted = 1'b1;
                        r.kind = KIND_PAYLOAD;
                        r.byte_out = it.byte_in;
                        r.last = (pay_left == 0);
                    end
                    else
                    begin
                        if (32'(pay_wp) < PAYLOAD_DEPTH)
                        begin
                            pay_mem[pay_wp[PAY_AW-1:0]] = it.byte_in;
                            pay_wp++;
                            asm_bytes++;
                            if (32'(pay_wp) > pay_filled)
                                pay_filled = 32'(pay_wp);
                        end
                        if (asm_active && asm_bytes == asm_total)
                        begin
                            msgs_seen++;
                            emitted = 1'b1;
                            r.kind = KIND_COMPLETE;
                            r.message_length = 14'(asm_bytes);
                            r.message_topic_length = 7'(asm_topic_len);
                            clear_asm();
                            stop_bytes();
                        end
                    end
                end
            end
            FUNC_RESTART:
            begin
                clear_asm();
                stop_bytes();
            end
            FUNC_RD_PAY:
            begin
                emitted = 1'b1;
                r.kind = KIND_READ;
                r.byte_out = (32'(it.read_index) < PAYLOAD_DEPTH) ?
                             pay_mem[it.read_index[PAY_AW-1:0]] : 8'd0;
            end
            FUNC_RD_TOP:
            begin
                emitted = 1'b1;
                r.kind = KIND_READ;
                r.byte_out = (32'(it.read_index) < TOPIC_DEPTH) ?
                             top_mem[it.read_index[TOP_AW-1:0]] : 8'd0;
            end
            default: ;
        endcase
        if (emitted)
        begin
            r.message_count = msgs_seen;
            r.drop_count = drops_seen;
            due_results.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 200)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected transaction, kind %0d", got.kind));
            return;
        end
        want = due_results.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
        if (got.verdict !== want.verdict)
            report_mismatch($sformatf("verdict got %0d want %0d", got.verdict, want.verdict));
        if (got.byte_out !== want.byte_out)
            report_mismatch($sformatf("byte_out got %0h want %0h", got.byte_out, want.byte_out));
        if (got.last !== want.last)
            report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
        if (got.message_length !== want.message_length)
            report_mismatch($sformatf("message_length got %0d want %0d",
                                      got.message_length, want.message_length));
        if (got.message_topic_length !== want.message_topic_length)
            report_mismatch($sformatf("message_topic_length got %0d want %0d",
                                      got.message_topic_length, want.message_topic_length));
        if (got.message_count !== want.message_count)
            report_mismatch($sformatf("message_count got %0d want %0d",
                                      got.message_count, want.message_count));
        if (got.drop_count !== want.drop_count)
            report_mismatch($sformatf("drop_count got %0d want %0d",
                                      got.drop_count, want.drop_count));
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.data  <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                reassemble(req.data);
            if (!req.valid || req.ready)
            begin
                if (frag_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req.data  <= frag_backlog.pop_front();
                    req.valid <= 1'b1;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
                check_result(rsp.data);
            rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request)
            hold_left <= HOLD_CYCLES;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic frag_item_t blank_item(input logic [2:0] f);
        frag_item_t it;
        it.func         = f;
        it.frag_offset  = 20'($urandom);
        it.frag_len     = 16'($urandom);
        it.total_len    = 20'($urandom);
        it.topic_length = 16'($urandom);
        it.byte_in      = 8'($urandom);
        it.read_index   = 13'($urandom);
        return it;
    endfunction

    task automatic offer(input frag_item_t it);
        while (frag_backlog.size() >= BACKLOG_MAX)
            @(posedge clk);
        frag_backlog.push_back(it);
        offered++;
    endtask

    task automatic send_header(input int unsigned off, input int unsigned flen,
                               input int unsigned total, input int unsigned tlen);
        frag_item_t it;
        it = blank_item(FUNC_HEADER);
        it.frag_offset  = 20'(off);
        it.frag_len     = 16'(flen);
        it.total_len    = 20'(total);
        it.topic_length = 16'(tlen);
        offer(it);
    endtask

    task automatic send_bytes(input logic [2:0] f, input int unsigned n);
        repeat (n) offer(blank_item(f));
    endtask

    task automatic send_edge_byte(input logic [2:0] f, input logic [7:0] b);
        frag_item_t it;
        it = blank_item(f);
        it.byte_in = b;
        offer(it);
    endtask

    // Reads only touch entries already written, or topic indexes past the store.
    task automatic send_reads(input int unsigned n);
        frag_item_t it;
        repeat (n)
        begin
            if (pay_filled != 0 && $urandom_range(1) == 0)
            begin
                it = blank_item(FUNC_RD_PAY);
                it.read_index = 13'($urandom_range(0, pay_filled - 1));
            end
            else
            begin
                it = blank_item(FUNC_RD_TOP);
                if (top_filled != 0 && $urandom_range(4) != 0)
                    it.read_index = 13'($urandom_range(0, top_filled - 1));
                else
                    it.read_index = 13'($urandom_range(TOPIC_DEPTH, 8191));
            end
            offer(it);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (frag_backlog.size() != 0 || req.valid || due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_fragmented();
        int unsigned total;
        int unsigned tlen;
        int unsigned sent;
        int unsigned n;
        int unsigned twist;
        total = ($urandom_range(9) == 0) ? $urandom_range(64, 400) : $urandom_range(1, 24);
        tlen = ($urandom_range(7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
        sent = $urandom_range(0, total - 1);
        send_header(0, sent, total, tlen);
        send_bytes(FUNC_TOPIC, ($urandom_range(9) == 0) ? $urandom_range(0, tlen + 2) : tlen);
        send_bytes(FUNC_PAYLOAD, sent);
        while (sent < total)
        begin
            n = $urandom_range(1, total - sent);
            twist = $urandom_range(24);
            if (twist == 0)
                send_header(sent + 1, n, total, 0);
            else if (twist == 1)
                send_header(sent, total - sent + 1, total, 0);
            else if (twist == 2)
                offer(blank_item(FUNC_RESTART));
            if (twist <= 2)
                sent = total;
            else
            begin
                send_header(sent, n, total, $urandom_range(0, 3));
                send_bytes(FUNC_TOPIC, $urandom_range(0, 1));
                if (twist == 3)
                    send_bytes(FUNC_PAYLOAD, $urandom_range(0, n - 1));
                else if (twist == 4)
                    send_bytes(FUNC_PAYLOAD, n + 1);
                else
                    send_bytes(FUNC_PAYLOAD, n);
                sent += n;
            end
        end
    endtask

    task automatic send_fast_path();
        int unsigned total;
        int unsigned tlen;
        total = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 16);
        tlen = $urandom_range(0, 6);
        send_header(0, total, total, tlen);
        send_bytes(FUNC_TOPIC, tlen);
        send_bytes(FUNC_PAYLOAD, total + (($urandom_range(9) == 0) ? 1 : 0));
    endtask

    task automatic send_noise();
        case ($urandom_range(7))
            0: offer(blank_item(FUNC_HEADER));
            1: send_header(0, $urandom_range(0, 20), $urandom_range(0, 20),
                           $urandom_range(0, 130));
            2: send_header(0, $urandom_range(0, 10), $urandom_range(PAYLOAD_DEPTH + 1, 1048575),
                           $urandom_range(0, 65535));
            3: send_header($urandom_range(1, 30), $urandom_range(0, 10),
                           $urandom_range(1, 40), 0);
            4: offer(blank_item(FUNC_RESTART));
            5: offer(blank_item(3'($urandom_range(6, 7))));
            6: send_bytes(3'($urandom_range(FUNC_TOPIC, FUNC_PAYLOAD)), $urandom_range(1, 3));
            default:
            begin
                send_header(0, $urandom_range(0, 8), PAYLOAD_DEPTH, $urandom_range(0, 127));
                send_bytes(FUNC_PAYLOAD, $urandom_range(0, 4));
            end
        endcase
    endtask

    initial
    begin
        int unsigned pick;
        bit          held;
        bit          paused;
        held = 1'b0;
        paused = 1'b0;
        rst_n = 1'b0;
        hold_request = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-length fast path, then a two-byte fast path with surplus byte
        send_header(0, 0, 0, 5);
        send_header(0, 2, 2, 1);
        send_edge_byte(FUNC_TOPIC, 8'hFF);
        send_edge_byte(FUNC_PAYLOAD, 8'h00);
        send_edge_byte(FUNC_PAYLOAD, 8'hFF);
        send_edge_byte(FUNC_PAYLOAD, 8'h5A);
        // continuation with nothing started, then the three first-fragment rejects
        send_header(20'hFFFFF, 1, 10, 0);
        send_header(0, 1, PAYLOAD_DEPTH + 1, 0);
        send_header(0, 1, 10, TOPIC_DEPTH);
        send_header(0, 5, 3, 0);
        // started message interrupted by a fast path, then completed
        send_header(0, 2, 4, 2);
        send_bytes(FUNC_TOPIC, 2);
        send_bytes(FUNC_PAYLOAD, 2);
        send_header(0, 1, 1, 0);
        send_bytes(FUNC_PAYLOAD, 1);
        send_header(2, 2, 4, 0);
        send_bytes(FUNC_TOPIC, 1);
        send_bytes(FUNC_PAYLOAD, 2);
        // out-of-order continuation, largest total, restart, unused funcs
        send_header(0, 1, 3, 0);
        send_bytes(FUNC_PAYLOAD, 1);
        send_header(2, 1, 3, 0);
        send_header(0, 0, PAYLOAD_DEPTH, TOPIC_DEPTH - 1);
        offer(blank_item(FUNC_RESTART));
        offer(blank_item(3'd6));
        offer(blank_item(3'd7));
        wait_drained();
        send_reads(6);

        while (offered < ITEM_TARGET)
        begin
            case ((offered / 160) % 4)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 54; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 54; end
                default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
            endcase
            if (!held && offered >= 500)
            begin
                held = 1'b1;
                @(posedge clk);
                hold_request <= 1'b1;
                @(posedge clk);
                hold_request <= 1'b0;
            end
            if (!paused && offered >= 850)
            begin
                paused = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < 40)
                send_fragmented();
            else if (pick < 60)
                send_fast_path();
            else if (pick < 72)
                send_reads($urandom_range(1, 4));
            else
                send_noise();
        end

        send_idle_pct = 0;
        rsp_stall_pct = 0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d transactions never arrived", due_results.size()));
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
